/* src/hbc_pkg.sv */
// ----------------------------------------------------------------------------
// hbc_pkg: shared types and constants of the H-bridge current controller
// Register indexes, field widths and the configuration bundle.
// ----------------------------------------------------------------------------
package hbc_pkg;

  // Field widths.
  localparam int unsigned CurW    = 16;  // Q3.12 current input
  localparam int unsigned ErrW    = 17;  // error, Q4.12
  localparam int unsigned SumW    = 32;  // error sum
  localparam int unsigned GainW   = 18;  // Q.8 / Q.16 gains
  localparam int unsigned VoltW   = 17;  // Q4.12 command
  localparam int unsigned LimW    = 16;  // supply limit
  localparam int unsigned DgW     = 24;  // duty gain
  localparam int unsigned DutyW   = 8;   // PWM counts
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDatW = 24;
  localparam int unsigned InDatW  = 32;
  localparam int unsigned OutDatW = 40;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    REG_PROP_GAIN     = 3'd0,
    REG_INTEG_GAIN_TS = 3'd1,
    REG_DERIV_GAIN_TS = 3'd2,
    REG_VOLT_OFFSET   = 3'd3,
    REG_SUPPLY_LIMIT  = 3'd4,
    REG_DUTY_GAIN     = 3'd5
  } cfg_idx_t;

  // Reset values of the registers.
  localparam logic [GainW-1:0]        PropGainRst   = 18'd25600;
  localparam logic [GainW-1:0]        IntegGainRst  = 18'd0;
  localparam logic [GainW-1:0]        DerivGainRst  = 18'd0;
  localparam logic signed [VoltW-1:0] VoltOffsetRst = 17'sd0;
  localparam logic [LimW-1:0]         SupplyLimRst  = 16'd40960;
  localparam logic [DgW-1:0]          DutyGainRst   = 24'd104448;

  // Largest PWM count.
  localparam logic [DutyW-1:0] DutyMax = 8'd255;

  // Configuration bundle handed to the datapath.
  typedef struct packed {
    logic [GainW-1:0]        prop_gain;
    logic [GainW-1:0]        integral_gain_ts;
    logic [GainW-1:0]        deriv_gain_over_ts;
    logic signed [VoltW-1:0] voltage_offset;
    logic [LimW-1:0]         supply_limit;
    logic [DgW-1:0]          duty_gain;
  } hbc_cfg_t;

endpackage

/* src/hbc_cfg_regs.sv */
// ----------------------------------------------------------------------------
// hbc_cfg_regs: configuration register file
// Takes one register write per cycle; writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
module hbc_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [hbc_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [hbc_pkg::CfgDatW-1:0]   cfg_data,
  output hbc_pkg::hbc_cfg_t             cfg_out
);
  import hbc_pkg::*;

  hbc_cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg_out   = cfg_r;

  // Register writes, each truncated to its register's width.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.prop_gain          <= PropGainRst;
      cfg_r.integral_gain_ts   <= IntegGainRst;
      cfg_r.deriv_gain_over_ts <= DerivGainRst;
      cfg_r.voltage_offset     <= VoltOffsetRst;
      cfg_r.supply_limit       <= SupplyLimRst;
      cfg_r.duty_gain          <= DutyGainRst;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        REG_PROP_GAIN:     cfg_r.prop_gain          <= cfg_data[GainW-1:0];
        REG_INTEG_GAIN_TS: cfg_r.integral_gain_ts   <= cfg_data[GainW-1:0];
        REG_DERIV_GAIN_TS: cfg_r.deriv_gain_over_ts <= cfg_data[GainW-1:0];
        REG_VOLT_OFFSET:   cfg_r.voltage_offset     <= $signed(cfg_data[VoltW-1:0]);
        REG_SUPPLY_LIMIT:  cfg_r.supply_limit       <= cfg_data[LimW-1:0];
        REG_DUTY_GAIN:     cfg_r.duty_gain          <= cfg_data[DgW-1:0];
        default: ;
      endcase
    end
  end

endmodule

/* src/hbc_pid_core.sv */
// ----------------------------------------------------------------------------
// hbc_pid_core: PID step with saturating integrator and anti-windup
// Forms the clamped volt command for one item and updates the loop state.
// ----------------------------------------------------------------------------
module hbc_pid_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                load,     // item moves on
  input  logic                                upd,      // item is real
  input  logic signed [hbc_pkg::CurW-1:0]     ref_cur,
  input  logic signed [hbc_pkg::CurW-1:0]     meas_cur,
  input  hbc_pkg::hbc_cfg_t                   cfg,
  output logic signed [hbc_pkg::VoltW-1:0]    volt,
  output logic                                clamped
);
  import hbc_pkg::*;

  localparam int unsigned PW = 36;  // proportional and derivative products
  localparam int unsigned IW = 50;  // integral product
  localparam int unsigned AW = 52;  // accumulator, Q.28
  localparam int unsigned VW = AW - 16;

  logic signed [SumW-1:0]  err_sum_r, err_sum_nxt;
  logic signed [ErrW-1:0]  last_err_r;
  logic signed [VoltW-1:0] volt_r, volt_nxt;
  logic                    clamp_r, clamp_nxt;

  logic signed [ErrW-1:0]  err;
  logic signed [ErrW:0]    derr;
  logic signed [SumW:0]    sum_wide;
  logic signed [SumW-1:0]  sum_sat;
  logic signed [PW-1:0]    prod_p, prod_d;
  logic signed [IW-1:0]    prod_i;
  logic signed [AW-1:0]    acc;
  logic signed [VW-1:0]    v_full, lim_pos, lim_neg;
  logic                    over_hi, over_lo, err_pos, err_neg;

  // Error, its change and the saturating sum.
  always_comb begin
    err      = ErrW'($signed({ref_cur[CurW-1], ref_cur}) - $signed({meas_cur[CurW-1], meas_cur}));
    derr     = $signed({err[ErrW-1], err}) - $signed({last_err_r[ErrW-1], last_err_r});
    sum_wide = $signed({err_sum_r[SumW-1], err_sum_r})
             + $signed({{(SumW+1-ErrW){err[ErrW-1]}}, err});
    if (sum_wide[SumW] != sum_wide[SumW-1]) begin
      sum_sat = sum_wide[SumW] ? {1'b1, {(SumW-1){1'b0}}} : {1'b0, {(SumW-1){1'b1}}};
    end else begin
      sum_sat = sum_wide[SumW-1:0];
    end
  end

  // Gain products and the exact sum in Q.28, floored to Q.12.
  always_comb begin
    prod_p = $signed({{(PW-GainW){1'b0}}, cfg.prop_gain})
           * $signed({{(PW-ErrW){err[ErrW-1]}}, err});
    prod_i = $signed({{(IW-GainW){1'b0}}, cfg.integral_gain_ts})
           * $signed({{(IW-SumW){sum_sat[SumW-1]}}, sum_sat});
    prod_d = $signed({{(PW-GainW){1'b0}}, cfg.deriv_gain_over_ts})
           * $signed({{(PW-ErrW-1){derr[ErrW]}}, derr});
    acc = $signed({{(AW-PW-8){prod_p[PW-1]}}, prod_p, 8'b0})
        + $signed({{(AW-IW){prod_i[IW-1]}}, prod_i})
        + $signed({{(AW-PW-8){prod_d[PW-1]}}, prod_d, 8'b0})
        + $signed({{(AW-VoltW-16){cfg.voltage_offset[VoltW-1]}}, cfg.voltage_offset, 16'b0});
    v_full = acc[AW-1:16];
  end

  // Clamp to the supply and decide on anti-windup.
  always_comb begin
    lim_pos = $signed({{(VW-LimW){1'b0}}, cfg.supply_limit});
    lim_neg = -lim_pos;
    over_hi = v_full > lim_pos;
    over_lo = v_full < lim_neg;
    err_pos = !err[ErrW-1] && (err != '0);
    err_neg = err[ErrW-1];
    if (over_hi) begin
      volt_nxt = lim_pos[VoltW-1:0];
    end else if (over_lo) begin
      volt_nxt = lim_neg[VoltW-1:0];
    end else begin
      volt_nxt = v_full[VoltW-1:0];
    end
    clamp_nxt = over_hi || over_lo;
    if ((over_hi && err_pos) || (over_lo && err_neg)) begin
      err_sum_nxt = err_sum_r;
    end else begin
      err_sum_nxt = sum_sat;
    end
  end

  // Loop state advances once per real item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      err_sum_r  <= '0;
      last_err_r <= '0;
    end else if (load && upd) begin
      err_sum_r  <= err_sum_nxt;
      last_err_r <= err;
    end
  end

  // Command register.
  always_ff @(posedge clk) begin
    if (load) begin
      volt_r  <= volt_nxt;
      clamp_r <= clamp_nxt;
    end
  end

  assign volt    = volt_r;
  assign clamped = clamp_r;

endmodule

/* src/hbc_duty.sv */
// ----------------------------------------------------------------------------
// hbc_duty: PWM duty scaling and bridge side steering
// Scales the command magnitude to 8-bit counts and registers the result item.
// ----------------------------------------------------------------------------
module hbc_duty (
  input  logic                              clk,
  input  logic                              load,
  input  logic signed [hbc_pkg::VoltW-1:0]  volt,
  input  logic                              clamped,
  input  logic [hbc_pkg::DgW-1:0]           duty_gain,
  output logic [hbc_pkg::OutDatW-1:0]       result
);
  import hbc_pkg::*;

  localparam int unsigned MW = LimW + DgW;

  logic [LimW-1:0]      mag;
  logic [MW-1:0]        prod;
  logic [MW-DgW-1:0]    duty_raw;
  logic [DutyW-1:0]     duty;
  logic [DutyW-1:0]     right_duty, left_duty;
  logic [OutDatW-1:0]   result_r;

  // Magnitude times gain, top bits saturated to one byte.
  always_comb begin
    mag      = volt[VoltW-1] ? LimW'(-volt) : volt[LimW-1:0];
    prod     = {{DgW{1'b0}}, mag} * {{LimW{1'b0}}, duty_gain};
    duty_raw = prod[MW-1:DgW];
    duty     = (duty_raw > {{(MW-DgW-DutyW){1'b0}}, DutyMax}) ? DutyMax : duty_raw[DutyW-1:0];
    right_duty = volt[VoltW-1] ? '0 : duty;
    left_duty  = volt[VoltW-1] ? duty : '0;
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (load) begin
      result_r <= {{(OutDatW-2*DutyW-VoltW-1){1'b0}}, clamped, volt, left_duty, right_duty};
    end
  end

  assign result = result_r;

endmodule

/* src/pid_hbridge_current_controller.sv */
// ----------------------------------------------------------------------------
// pid_hbridge_current_controller: PID current loop for an H-bridge
// Items pass the input register, then the command and result registers; the
// input register loads at the accepting edge. Throughput: one item per cycle
// while no untaken result stalls the pipe; the PID step closes the error-sum
// loop combinationally. Reset clears the error sum, last error and valid flags
// and loads the configuration defaults; data registers are not reset.
// ----------------------------------------------------------------------------
module pid_hbridge_current_controller (
  input  logic                            clk,
  input  logic                            rst_n,
  // Input stream.
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [hbc_pkg::InDatW-1:0]      in_tdata,   // reference_current, measured_current
  // Result stream.
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [hbc_pkg::OutDatW-1:0]     out_tdata,  // right_duty, left_duty,
                                                      // voltage_command, clamped, zero pad
  // Configuration writes.
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [hbc_pkg::CfgIdxW-1:0]     cfg_index,
  input  logic [hbc_pkg::CfgDatW-1:0]     cfg_data
);
  import hbc_pkg::*;

  hbc_cfg_t                cfg;
  logic                    adv;
  logic                    in_vld_r, cmd_vld_r, out_vld_r;
  logic signed [CurW-1:0]  ref_r, meas_r;
  logic signed [VoltW-1:0] volt;
  logic                    clamped;

  // The whole pipe moves unless a result sits untaken.
  assign adv        = !out_vld_r || out_tready;
  assign in_tready  = adv;
  assign out_tvalid = out_vld_r;

  // Valid flags for each stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      cmd_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (adv) begin
      in_vld_r  <= in_tvalid;
      cmd_vld_r <= in_vld_r;
      out_vld_r <= cmd_vld_r;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (adv) begin
      ref_r  <= $signed(in_tdata[CurW-1:0]);
      meas_r <= $signed(in_tdata[2*CurW-1:CurW]);
    end
  end

  hbc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_out   (cfg)
  );

  hbc_pid_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (adv),
    .upd      (in_vld_r),
    .ref_cur  (ref_r),
    .meas_cur (meas_r),
    .cfg      (cfg),
    .volt     (volt),
    .clamped  (clamped)
  );

  hbc_duty u_duty (
    .clk       (clk),
    .load      (adv),
    .volt      (volt),
    .clamped   (clamped),
    .duty_gain (cfg.duty_gain),
    .result    (out_tdata)
  );

endmodule
